### design/ryuv_pkg.sv
package ryuv_pkg;

    // Fixed field widths
    localparam int unsigned MAX_DIM_DEFAULT = 4096;
    localparam int unsigned CFG_W           = 13;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned PIX_W           = 8;
    localparam int unsigned NUM_W           = 15;
    localparam int unsigned LADDR_W         = 24;
    localparam int unsigned CADDR_W         = 25;
    localparam int unsigned COFF_W          = 22;
    localparam int unsigned PROD_W          = 2 * CFG_W;
    localparam int unsigned IN_TDATA_W      = 3 * PIX_W;
    localparam int unsigned OUT_FIELDS_W    = 3 * PIX_W + LADDR_W + 2 * CADDR_W;
    localparam int unsigned OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [CFG_W-1:0]  RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0]  RST_HEIGHT = CFG_W'(480);
    localparam logic [PROD_W-1:0] RST_SPAN   = PROD_W'((480 - 1) * 640);
    localparam logic [PROD_W-1:0] RST_PLANE  = PROD_W'(480 * 640);

    // Color coefficients (scaled by 100)
    localparam logic [NUM_W:0] COEF_YR  = (NUM_W+1)'(30);
    localparam logic [NUM_W:0] COEF_YG  = (NUM_W+1)'(59);
    localparam logic [NUM_W:0] COEF_YB  = (NUM_W+1)'(11);
    localparam logic [NUM_W:0] COEF_UR  = (NUM_W+1)'(17);
    localparam logic [NUM_W:0] COEF_UG  = (NUM_W+1)'(33);
    localparam logic [NUM_W:0] COEF_UB  = (NUM_W+1)'(50);
    localparam logic [NUM_W:0] COEF_VR  = (NUM_W+1)'(50);
    localparam logic [NUM_W:0] COEF_VG  = (NUM_W+1)'(42);
    localparam logic [NUM_W:0] COEF_VB  = (NUM_W+1)'(8);
    localparam logic [NUM_W:0] C_OFFSET = (NUM_W+1)'(12800);

    // Divide by 100: ceil(2^32/100), exact for all numerators below 2^15
    localparam int unsigned     RECIP_W     = 26;
    localparam int unsigned     RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(42949673);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FLIP   = 2'd2
    } t_cfg_index;

    // Effective frame setup, held by the config block
    typedef struct packed {
        logic [CFG_W-1:0]  width;
        logic [CFG_W-1:0]  height;
        logic              flip;
        logic [PROD_W-1:0] span;   // (height-1)*width
        logic [PROD_W-1:0] plane;  // height*width
    } t_frame_cfg;

    // Per-item address and flag info from the raster counters
    typedef struct packed {
        logic [LADDR_W-1:0] luma_addr;
        logic [CADDR_W-1:0] chroma_ofs;
        logic               chroma_valid;
        logic               eof;
    } t_px_ctrl;

    function automatic logic [NUM_W-1:0] luma_num(input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] r);
        logic [NUM_W:0] s;
        s = COEF_YR * (NUM_W+1)'(r) + COEF_YG * (NUM_W+1)'(g) + COEF_YB * (NUM_W+1)'(b);
        return s[NUM_W-1:0];
    endfunction

    // Always lands in 50..25550, so the low NUM_W bits are the full value
    function automatic logic [NUM_W-1:0] u_num(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
        logic [NUM_W:0] s;
        s = C_OFFSET + COEF_UB * (NUM_W+1)'(b) - COEF_UR * (NUM_W+1)'(r)
            - COEF_UG * (NUM_W+1)'(g);
        return s[NUM_W-1:0];
    endfunction

    function automatic logic [NUM_W-1:0] v_num(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
        logic [NUM_W:0] s;
        s = C_OFFSET + COEF_VR * (NUM_W+1)'(r) - COEF_VG * (NUM_W+1)'(g)
            - COEF_VB * (NUM_W+1)'(b);
        return s[NUM_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] div100(input logic [NUM_W-1:0] n);
        logic [NUM_W+RECIP_W-1:0] p;
        p = (NUM_W+RECIP_W)'(n) * (NUM_W+RECIP_W)'(RECIP_100);
        return p[RECIP_SHIFT +: PIX_W];
    endfunction

endpackage

### design/ryuv_cfg_regs.sv
module ryuv_cfg_regs
    import ryuv_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = MAX_DIM_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_W-1:0]     i_data,
    output t_frame_cfg           o_cfg,
    output logic                 o_restart
);

    t_frame_cfg       r_cfg;
    t_frame_cfg       n_cfg;
    logic             hit;

    function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] c;
        c = w;
        if (32'(w) < 32'd2) begin
            c = CFG_W'(2);
        end else if (32'(w) > 32'(MAX_DIMENSION)) begin
            c = CFG_W'(MAX_DIMENSION);
        end
        return {c[CFG_W-1:1], 1'b0};
    endfunction

    function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] h);
        logic [CFG_W-1:0] c;
        c = h;
        if (h == '0) begin
            c = CFG_W'(1);
        end else if (32'(h) > 32'(MAX_DIMENSION)) begin
            c = CFG_W'(MAX_DIMENSION);
        end
        return c;
    endfunction

    // Merge the write into the held setup and form the frame products
    always_comb begin
        n_cfg = r_cfg;
        hit   = 1'b0;
        if (i_we) begin
            case (i_index)
                CFG_WIDTH: begin
                    n_cfg.width = clamp_width(i_data);
                    hit         = 1'b1;
                end
                CFG_HEIGHT: begin
                    n_cfg.height = clamp_height(i_data);
                    hit          = 1'b1;
                end
                CFG_FLIP: begin
                    n_cfg.flip = i_data[0];
                    hit        = 1'b1;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
        n_cfg.span  = PROD_W'(n_cfg.height - CFG_W'(1)) * PROD_W'(n_cfg.width);
        n_cfg.plane = PROD_W'(n_cfg.height) * PROD_W'(n_cfg.width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.flip   <= 1'b0;
            r_cfg.span   <= RST_SPAN;
            r_cfg.plane  <= RST_PLANE;
        end else if (hit) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_restart = hit;

endmodule

### design/ryuv_raster.sv
module ryuv_raster
    import ryuv_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = MAX_DIM_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame_cfg i_cfg,
    input  logic       i_restart,
    input  logic       i_advance,
    output t_px_ctrl   o_ctrl
);

    localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);

    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_dest, n_dest;
    logic [LADDR_W-1:0] r_lbase, n_lbase;
    logic [COFF_W-1:0]  r_cbase, n_cbase;
    logic               r_fresh, n_fresh;

    logic [CNT_W-1:0]   start_dest, cur_dest;
    logic [LADDR_W-1:0] start_l, cur_l;
    logic [COFF_W-1:0]  start_c, cur_c, half_w;
    logic [PROD_W-1:0]  span_even;
    logic               last_col, last_row, odd_tail;

    // Row bases at the top of the frame (bottom row when flipped)
    always_comb begin
        span_even  = i_cfg.span - (i_cfg.height[0] ? '0 : PROD_W'(i_cfg.width));
        start_dest = i_cfg.flip ? CNT_W'(i_cfg.height - CFG_W'(1)) : '0;
        start_l    = i_cfg.flip ? i_cfg.span[LADDR_W-1:0] : '0;
        start_c    = i_cfg.flip ? span_even[COFF_W+1:2] : '0;
        cur_dest   = r_fresh ? start_dest : r_dest;
        cur_l      = r_fresh ? start_l : r_lbase;
        cur_c      = r_fresh ? start_c : r_cbase;
        half_w     = COFF_W'(i_cfg.width[CFG_W-1:1]);
    end

    // Position flags and addresses of the current item
    always_comb begin
        last_col = (32'(r_col) + 32'd1 >= 32'(i_cfg.width));
        last_row = (32'(r_row) + 32'd1 >= 32'(i_cfg.height));
        odd_tail = i_cfg.height[0] && (32'(cur_dest) + 32'd1 == 32'(i_cfg.height));
        o_ctrl.luma_addr    = cur_l + LADDR_W'(r_col);
        o_ctrl.chroma_ofs   = CADDR_W'(cur_c) + CADDR_W'(r_col >> 1);
        o_ctrl.chroma_valid = r_col[0] && (cur_dest[0] || odd_tail);
        o_ctrl.eof          = last_col && last_row;
    end

    // Counter and row base stepping
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_dest  = r_dest;
        n_lbase = r_lbase;
        n_cbase = r_cbase;
        n_fresh = r_fresh;
        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_fresh = 1'b1;
        end else if (i_advance) begin
            n_fresh = 1'b0;
            n_dest  = cur_dest;
            n_lbase = cur_l;
            n_cbase = cur_c;
            if (!last_col) begin
                n_col = r_col + CNT_W'(1);
            end else begin
                n_col = '0;
                if (last_row) begin
                    n_row   = '0;
                    n_fresh = 1'b1;
                end else begin
                    n_row = r_row + CNT_W'(1);
                    if (i_cfg.flip) begin
                        n_dest  = cur_dest - CNT_W'(1);
                        n_lbase = cur_l - LADDR_W'(i_cfg.width);
                        n_cbase = cur_dest[0] ? cur_c : cur_c - half_w;
                    end else begin
                        n_dest  = cur_dest + CNT_W'(1);
                        n_lbase = cur_l + LADDR_W'(i_cfg.width);
                        n_cbase = cur_dest[0] ? cur_c + half_w : cur_c;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_dest  <= '0;
            r_lbase <= '0;
            r_cbase <= '0;
            r_fresh <= 1'b1;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_dest  <= n_dest;
            r_lbase <= n_lbase;
            r_cbase <= n_cbase;
            r_fresh <= n_fresh;
        end
    end

endmodule

### design/ryuv_convert.sv
module ryuv_convert
    import ryuv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PROD_W-1:0]  i_plane,
    input  logic               i_s_valid,
    input  logic [PIX_W-1:0]   i_blue,
    input  logic [PIX_W-1:0]   i_green,
    input  logic [PIX_W-1:0]   i_red,
    input  t_px_ctrl           i_ctrl,
    output logic               o_s_ready,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    output logic [PIX_W-1:0]   o_luma,
    output logic [LADDR_W-1:0] o_luma_address,
    output logic               o_chroma_valid,
    output logic [PIX_W-1:0]   o_chroma_u,
    output logic [PIX_W-1:0]   o_chroma_v,
    output logic [CADDR_W-1:0] o_u_address,
    output logic [CADDR_W-1:0] o_v_address,
    output logic               o_end_of_frame
);

    // Stage 1: numerators and raster info
    logic               r_s1_valid;
    logic [NUM_W-1:0]   r_s1_ynum, r_s1_unum, r_s1_vnum;
    t_px_ctrl           r_s1_ctrl;

    // Stage 2: result register
    logic               r_s2_valid;
    logic [PIX_W-1:0]   r_luma, r_u, r_v;
    logic [LADDR_W-1:0] r_laddr;
    logic [CADDR_W-1:0] r_uaddr, r_vaddr;
    logic               r_cvalid, r_eof;

    logic               en1, en2, accept;
    logic [PROD_W-1:0]  plane_v, u_sum, v_sum;

    // Each stage moves when the one after it has room
    assign en2    = !r_s2_valid || i_m_ready;
    assign en1    = !r_s1_valid || en2;
    assign accept = i_s_valid && en1;

    always_comb begin
        plane_v = i_plane + (i_plane >> 2);
        u_sum   = i_plane + PROD_W'(r_s1_ctrl.chroma_ofs);
        v_sum   = plane_v + PROD_W'(r_s1_ctrl.chroma_ofs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= i_s_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ynum <= luma_num(i_blue, i_green, i_red);
            r_s1_unum <= u_num(i_blue, i_green, i_red);
            r_s1_vnum <= v_num(i_blue, i_green, i_red);
            r_s1_ctrl <= i_ctrl;
        end
    end

    // Divide by 100; chroma fields read zero where the write does not survive
    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            r_luma   <= div100(r_s1_ynum);
            r_laddr  <= r_s1_ctrl.luma_addr;
            r_cvalid <= r_s1_ctrl.chroma_valid;
            r_eof    <= r_s1_ctrl.eof;
            if (r_s1_ctrl.chroma_valid) begin
                r_u     <= div100(r_s1_unum);
                r_v     <= div100(r_s1_vnum);
                r_uaddr <= u_sum[CADDR_W-1:0];
                r_vaddr <= v_sum[CADDR_W-1:0];
            end else begin
                r_u     <= '0;
                r_v     <= '0;
                r_uaddr <= '0;
                r_vaddr <= '0;
            end
        end
    end

    assign o_s_ready      = en1;
    assign o_m_valid      = r_s2_valid;
    assign o_luma         = r_luma;
    assign o_luma_address = r_laddr;
    assign o_chroma_valid = r_cvalid;
    assign o_chroma_u     = r_u;
    assign o_chroma_v     = r_v;
    assign o_u_address    = r_uaddr;
    assign o_v_address    = r_vaddr;
    assign o_end_of_frame = r_eof;

endmodule

### design/rgb_to_yuv420_planar_core.sv
// An accepted input item passes through the numerator stage and then the result register.
// Throughput: one item per cycle while the output side accepts; the input side stays ready
// while a result waits, as long as the numerator stage has room.
// Reset: synchronous, active low; clears both pipeline stages and the raster
// counters, and loads width 640, height 480, no flip.
module rgb_to_yuv420_planar_core
    import ryuv_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = MAX_DIM_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Pixel input
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // blue[7:0], green[15:8], red[23:16]
    // Result output
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // luma[7:0], luma_address[31:8],
                                                // chroma_u[39:32], chroma_v[47:40],
                                                // u_address[72:48], v_address[97:73],
                                                // zero pad[103:98]
    output logic                   o_m_tuser,   // chroma_valid
    output logic                   o_m_tlast    // end_of_frame
);

    t_frame_cfg         cfg;
    t_px_ctrl           ctrl;
    logic               restart;
    logic               accept;
    logic [PIX_W-1:0]   luma, chroma_u, chroma_v;
    logic [LADDR_W-1:0] luma_address;
    logic [CADDR_W-1:0] u_address, v_address;

    assign accept = i_s_tvalid && o_s_tready;

    ryuv_cfg_regs #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_we),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    ryuv_raster #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_raster (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_advance (accept),
        .o_ctrl    (ctrl)
    );

    ryuv_convert u_convert (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_plane        (cfg.plane),
        .i_s_valid      (i_s_tvalid),
        .i_blue         (i_s_tdata[PIX_W-1:0]),
        .i_green        (i_s_tdata[2*PIX_W-1:PIX_W]),
        .i_red          (i_s_tdata[3*PIX_W-1:2*PIX_W]),
        .i_ctrl         (ctrl),
        .o_s_ready      (o_s_tready),
        .i_m_ready      (i_m_tready),
        .o_m_valid      (o_m_tvalid),
        .o_luma         (luma),
        .o_luma_address (luma_address),
        .o_chroma_valid (o_m_tuser),
        .o_chroma_u     (chroma_u),
        .o_chroma_v     (chroma_v),
        .o_u_address    (u_address),
        .o_v_address    (v_address),
        .o_end_of_frame (o_m_tlast)
    );

    // Pack result fields, first field lowest
    assign o_m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                        v_address, u_address, chroma_v, chroma_u, luma_address, luma};

endmodule

### design/ryuv_checker.sv
module ryuv_checker
    import ryuv_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser,
    input logic                   o_m_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // With the output empty the pipe must take an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // Surviving chroma only on odd columns, so the luma address is odd
    a_chroma_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[PIX_W])
        else $error("chroma flagged on even column");

    // Chroma fields read zero when not flagged
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[OUT_FIELDS_W-1:PIX_W+LADDR_W] == '0)
        else $error("chroma fields nonzero without flag");

endmodule

bind rgb_to_yuv420_planar_core ryuv_checker u_ryuv_checker (.*);
